// ===== rtl/twrm_pkg.sv =====
// Shared types, widths and constants for the time-weighted RMS meter.
package twrm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int SMP_W       = 12;
    localparam int TS_W        = 32;
    localparam int DELTA_W     = 16;
    localparam int SQ_W        = 2 * SMP_W;
    localparam int TERM_W      = SQ_W + DELTA_W;
    localparam int ACC_W       = 48;
    localparam int TICK_W      = 22;
    localparam int ROOT_W      = ACC_W / 2;
    localparam int GAIN_W      = 16;
    localparam int PROD_W      = ROOT_W + GAIN_W;
    localparam int RMS_W       = 20;
    localparam int WIN_W       = 6;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SMP_W-1:0]   SAMPLE_MASK     = SMP_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [DELTA_W-1:0] MAX_DELTA_TICKS = DELTA_W'(65535);

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN   = 2'd2;

    localparam logic [WIN_W-1:0]  WINDOW_RST = WIN_W'(16);
    localparam logic [SMP_W-1:0]  OFFSET_RST = SMP_W'(0);
    localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(12390);

    // one classified sample handed from front to back
    typedef struct packed {
        logic [SMP_W-1:0]   mag;
        logic [DELTA_W-1:0] delta;
        logic               last;
    } item_t;

endpackage

// ===== rtl/twrm_front.sv =====
// Front end: takes sample words, computes tick delta and magnitude, marks window end.
module twrm_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [twrm_pkg::SMP_W-1:0]        s_sample,
    input  logic [twrm_pkg::TS_W-1:0]         s_timestamp,
    input  logic [twrm_pkg::WIN_W-1:0]        window_samples,
    input  logic [twrm_pkg::SMP_W-1:0]        sample_offset,
    input  logic                              fifo_full,
    output logic                              push,
    output twrm_pkg::item_t                   push_item
);

    logic [twrm_pkg::TS_W-1:0]  last_ts_reg;
    logic [twrm_pkg::WIN_W-1:0] count_reg;
    logic [twrm_pkg::WIN_W-1:0] count_next;
    logic [twrm_pkg::WIN_W-1:0] win;
    logic [twrm_pkg::TS_W-1:0]  delta_full;
    logic [twrm_pkg::SMP_W-1:0] smp;
    logic                       last;

    assign s_ready = !fifo_full;
    assign push    = s_valid && !fifo_full;

    assign smp        = s_sample & twrm_pkg::SAMPLE_MASK;
    assign delta_full = s_timestamp - last_ts_reg;
    assign count_next = count_reg + twrm_pkg::WIN_W'(1);
    assign win        = (window_samples == '0) ? twrm_pkg::WIN_W'(1) : window_samples;
    assign last       = !((count_next < win) && (count_next != '0));

    always_comb begin
        push_item.mag  = (smp >= sample_offset) ? (smp - sample_offset)
                                                : (sample_offset - smp);
        if (delta_full > twrm_pkg::TS_W'(twrm_pkg::MAX_DELTA_TICKS)) begin
            push_item.delta = twrm_pkg::MAX_DELTA_TICKS;
        end else begin
            push_item.delta = delta_full[twrm_pkg::DELTA_W-1:0];
        end
        push_item.last = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_ts_reg <= '0;
            count_reg   <= '0;
        end else if (push) begin
            last_ts_reg <= s_timestamp;
            count_reg   <= last ? '0 : count_next;
        end
    end

endmodule

// ===== rtl/twrm_fifo.sv =====
// Two-entry queue between front and back.
module twrm_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  twrm_pkg::item_t push_item,
    input  logic            pop,
    output twrm_pkg::item_t pop_item,
    output logic            full,
    output logic            empty
);

    twrm_pkg::item_t mem [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      fill_reg;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/twrm_root.sv =====
// Serial unit: restoring divide of the weighted sum by ticks, then bitwise square root.
module twrm_root (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [twrm_pkg::ACC_W-1:0]    dividend,
    input  logic [twrm_pkg::TICK_W-1:0]   divisor,
    output logic                          done,
    output logic [twrm_pkg::ROOT_W-1:0]   root
);

    localparam int CNT_W   = $clog2(twrm_pkg::ACC_W);
    localparam int SREM_W  = twrm_pkg::ROOT_W + 2;

    typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} state_t;

    state_t                        state_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [twrm_pkg::ACC_W-1:0]    work_reg;
    logic [twrm_pkg::TICK_W-1:0]   div_reg;
    logic [twrm_pkg::TICK_W-1:0]   rem_reg;
    logic [SREM_W-1:0]             srem_reg;
    logic [twrm_pkg::ROOT_W-1:0]   root_reg;
    logic                          done_reg;

    logic [twrm_pkg::TICK_W:0]     rem_sh;
    logic                          div_ge;
    logic [twrm_pkg::TICK_W:0]     rem_sub;
    logic [SREM_W+1:0]             srem_sh;
    logic [SREM_W+1:0]             trial;
    logic                          sq_ge;
    logic [SREM_W+1:0]             srem_sub;

    assign rem_sh  = {rem_reg, work_reg[twrm_pkg::ACC_W-1]};
    assign div_ge  = rem_sh >= {1'b0, div_reg};
    assign rem_sub = rem_sh - {1'b0, div_reg};

    // two radicand bits enter per step; trial is 4*root + 1
    assign srem_sh  = {srem_reg, work_reg[twrm_pkg::ACC_W-1 -: 2]};
    assign trial    = (SREM_W + 2)'({root_reg, 2'b01});
    assign sq_ge    = srem_sh >= trial;
    assign srem_sub = srem_sh - trial;

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                R_IDLE: begin
                    done_reg <= 1'b0;
                    if (start) begin
                        // zero tick total gives a zero mean: 0 divided by all ones
                        work_reg  <= (divisor == '0) ? '0 : dividend;
                        div_reg   <= (divisor == '0) ? '1 : divisor;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= R_DIV;
                    end
                end
                R_DIV: begin
                    work_reg <= {work_reg[twrm_pkg::ACC_W-2:0], div_ge};
                    rem_reg  <= div_ge ? rem_sub[twrm_pkg::TICK_W-1:0]
                                       : rem_sh[twrm_pkg::TICK_W-1:0];
                    if (cnt_reg == CNT_W'(twrm_pkg::ACC_W - 1)) begin
                        cnt_reg   <= '0;
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        state_reg <= R_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                R_SQRT: begin
                    work_reg <= {work_reg[twrm_pkg::ACC_W-3:0], 2'b00};
                    srem_reg <= sq_ge ? srem_sub[SREM_W-1:0] : srem_sh[SREM_W-1:0];
                    root_reg <= {root_reg[twrm_pkg::ROOT_W-2:0], sq_ge};
                    if (cnt_reg == CNT_W'(twrm_pkg::ROOT_W - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/twrm_back.sv =====
// Back end: weights and accumulates squares, runs the root unit at window end, scales output.
module twrm_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fifo_empty,
    input  twrm_pkg::item_t                pop_item,
    output logic                           pop,
    input  logic [twrm_pkg::GAIN_W-1:0]    gain_q8,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [twrm_pkg::RMS_W-1:0]     m_rms_value,
    output logic [twrm_pkg::TICK_W-1:0]    m_ticks_in_window
);

    typedef enum logic [2:0] {ST_IDLE, ST_TERM, ST_ACC, ST_ROOT, ST_SCALE, ST_EMIT} state_t;

    state_t                          state_reg;
    logic [twrm_pkg::SQ_W-1:0]       sq_reg;
    logic [twrm_pkg::DELTA_W-1:0]    delta_reg;
    logic                            last_reg;
    logic [twrm_pkg::TERM_W-1:0]     term_reg;
    logic [twrm_pkg::ACC_W-1:0]      acc_reg;
    logic [twrm_pkg::TICK_W-1:0]     tick_reg;
    logic                            start_reg;
    logic [twrm_pkg::PROD_W-1:0]     prod_reg;
    logic                            m_valid_reg;
    logic [twrm_pkg::RMS_W-1:0]      rms_reg;
    logic [twrm_pkg::TICK_W-1:0]     ticks_reg;

    logic [twrm_pkg::ACC_W:0]        acc_sum;
    logic [twrm_pkg::TICK_W:0]       tick_sum;
    logic [twrm_pkg::PROD_W-9:0]     scaled;
    logic                            root_done;
    logic [twrm_pkg::ROOT_W-1:0]     root_val;

    twrm_root u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (acc_reg),
        .divisor  (tick_reg),
        .done     (root_done),
        .root     (root_val)
    );

    assign pop      = (state_reg == ST_IDLE) && !fifo_empty;
    assign acc_sum  = {1'b0, acc_reg} + (twrm_pkg::ACC_W + 1)'(term_reg);
    assign tick_sum = {1'b0, tick_reg} + (twrm_pkg::TICK_W + 1)'(delta_reg);
    assign scaled   = prod_reg[twrm_pkg::PROD_W-1:8];

    assign m_valid           = m_valid_reg;
    assign m_rms_value       = rms_reg;
    assign m_ticks_in_window = ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            tick_reg    <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= (state_reg == ST_ACC) && last_reg;
            if ((state_reg == ST_EMIT) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!fifo_empty) begin
                        sq_reg    <= twrm_pkg::SQ_W'(pop_item.mag) *
                                     twrm_pkg::SQ_W'(pop_item.mag);
                        delta_reg <= pop_item.delta;
                        last_reg  <= pop_item.last;
                        state_reg <= ST_TERM;
                    end
                end
                ST_TERM: begin
                    term_reg  <= twrm_pkg::TERM_W'(sq_reg) * twrm_pkg::TERM_W'(delta_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    // both sums saturate
                    acc_reg   <= acc_sum[twrm_pkg::ACC_W] ? '1
                                                          : acc_sum[twrm_pkg::ACC_W-1:0];
                    tick_reg  <= tick_sum[twrm_pkg::TICK_W] ? '1
                                                            : tick_sum[twrm_pkg::TICK_W-1:0];
                    state_reg <= last_reg ? ST_ROOT : ST_IDLE;
                end
                ST_ROOT: begin
                    if (root_done) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    prod_reg  <= twrm_pkg::PROD_W'(root_val) * twrm_pkg::PROD_W'(gain_q8);
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        rms_reg     <= (|scaled[twrm_pkg::PROD_W-9:twrm_pkg::RMS_W]) ? '1
                                       : scaled[twrm_pkg::RMS_W-1:0];
                        ticks_reg   <= tick_reg;
                        acc_reg     <= '0;
                        tick_reg    <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/time_weighted_rms_meter_unit.sv =====
// Top level of the time-weighted RMS meter: config registers, front, queue and back.
//
// Each sample word is centered by sample_offset, squared and weighted by the tick
// delta to the previous word (saturated at 65535); the window sums saturate. When
// window_samples words have been taken the block divides the weighted sum by the tick
// total, takes the integer square root, multiplies by the Q8.8 gain and presents one
// result word (truncated, saturated to 20 bits) along with the window's tick total.
// A sample that does not close a window occupies the back end through its term and
// accumulate states. A sample that closes a window goes from acceptance through the
// queue, accumulation, the start of the root unit, the bit-serial divider, the
// bit-serial square-root unit and the scaling and registering of the result. A
// two-word queue lets the front accept further samples while the back end is busy.
// Config writes take effect at the next clock edge and are meant for when the block
// is idle.
module time_weighted_rms_meter_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [twrm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [twrm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [twrm_pkg::SMP_W-1:0]           s_sample,
    input  logic [twrm_pkg::TS_W-1:0]            s_timestamp,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [twrm_pkg::RMS_W-1:0]           m_rms_value,
    output logic [twrm_pkg::TICK_W-1:0]          m_ticks_in_window
);

    logic [twrm_pkg::WIN_W-1:0]  window_reg;
    logic [twrm_pkg::SMP_W-1:0]  offset_reg;
    logic [twrm_pkg::GAIN_W-1:0] gain_reg;

    logic            push;
    logic            pop;
    logic            fifo_full;
    logic            fifo_empty;
    twrm_pkg::item_t push_item;
    twrm_pkg::item_t pop_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= twrm_pkg::WINDOW_RST;
            offset_reg <= twrm_pkg::OFFSET_RST;
            gain_reg   <= twrm_pkg::GAIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                twrm_pkg::CFG_WINDOW: window_reg <= cfg_wdata[twrm_pkg::WIN_W-1:0];
                twrm_pkg::CFG_OFFSET: offset_reg <= cfg_wdata[twrm_pkg::SMP_W-1:0];
                twrm_pkg::CFG_GAIN:   gain_reg   <= cfg_wdata[twrm_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    twrm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_timestamp    (s_timestamp),
        .window_samples (window_reg),
        .sample_offset  (offset_reg),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_item      (push_item)
    );

    twrm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    twrm_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .fifo_empty        (fifo_empty),
        .pop_item          (pop_item),
        .pop               (pop),
        .gain_q8           (gain_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rms_value       (m_rms_value),
        .m_ticks_in_window (m_ticks_in_window)
    );

endmodule
